### rtl/matrix_multiply_engine_unit_assert.svh
// Assertion macros shared by the matrix multiply engine RTL.
`ifndef MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH
`define MATRIX_MULTIPLY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MME_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mme_pkg.sv
// Types and constants for the matrix multiply engine.
package mme_pkg;

   localparam int VALUE_W  = 16;
   localparam int RESULT_W = 32;
   localparam int ACC_W    = 40;
   localparam int IDX_W    = 4;
   localparam int DIM_W    = 5;
   localparam int TYPE_W   = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   localparam logic [RESULT_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [RESULT_W-1:0] Q_MIN = 32'h8000_0000;

   // request codes
   localparam logic [TYPE_W-1:0] REQ_LOAD_A  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_LOAD_B  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // control from the sequencer into the MAC pipeline
   typedef struct packed {
      logic clear;
      logic term_vld;
      logic term_zero;
   } mac_ctrl_type;

   // status back from the MAC pipeline
   typedef struct packed {
      logic busy;
      logic saturated;
   } mac_stat_type;

endpackage

### rtl/mme_mac.sv
// Multiply-accumulate pipeline with Q16.16 saturation.
module mme_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  mme_pkg::mac_ctrl_type               ctrl,
   input  logic signed [mme_pkg::VALUE_W-1:0]  a_data,
   input  logic signed [mme_pkg::VALUE_W-1:0]  b_data,
   output mme_pkg::mac_stat_type               stat,
   output logic [mme_pkg::RESULT_W-1:0]        result
);

   logic signed [mme_pkg::RESULT_W-1:0] prod_ff, prod_in;
   logic                                prod_vld_ff;
   logic [mme_pkg::ACC_W-1:0]           acc_ff, acc_in;
   logic [mme_pkg::ACC_W-mme_pkg::RESULT_W:0] acc_hi;
   logic                                ovf;

   // product stage; out-of-range rows or columns read as zero
   always_comb begin
      if (ctrl.term_zero) begin
         prod_in = '0;
      end else begin
         prod_in = a_data * b_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.term_vld & ~ctrl.clear;
      end
      prod_ff <= prod_in;
   end

   // accumulate stage, sign-extended product
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + {{(mme_pkg::ACC_W-mme_pkg::RESULT_W){prod_ff[mme_pkg::RESULT_W-1]}},
                            prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // clamp to signed 32 bits
   assign acc_hi = acc_ff[mme_pkg::ACC_W-1:mme_pkg::RESULT_W-1];
   assign ovf    = ~((&acc_hi) | (~|acc_hi));

   always_comb begin
      if (!ovf) begin
         result = acc_ff[mme_pkg::RESULT_W-1:0];
      end else if (acc_ff[mme_pkg::ACC_W-1]) begin
         result = mme_pkg::Q_MIN;
      end else begin
         result = mme_pkg::Q_MAX;
      end
   end

   assign stat.busy      = prod_vld_ff;
   assign stat.saturated = ovf;

endmodule

### rtl/matrix_multiply_engine_unit.sv
// Top level of the matrix multiply engine: element stores, sequencer, result register.
//
//  channel  direction  handshake              payload
//  req      in         req_valid / req_stall  req_req_type, req_row, req_col, req_value
//  rsp      out        rsp_valid / rsp_stall  rsp_out_row, rsp_out_col,
//                                             rsp_product_value, rsp_saturated
//  csr      in         csr_wr_en              csr_wr_data (dim_in_use)
//
// A load request writes one store entry.
// A compute reads len = min(dim_in_use, MAX_DIM) element pairs: one element
// pair is read per cycle from the single read port of each store and fed to one MAC.
// Requests are held off (req_stall) while a compute is in progress, and longer while
// a stalled result still sits in the output register; otherwise the next request is taken.
// Reset is synchronous; the stores are not cleared.
module matrix_multiply_engine_unit #(
   parameter int MAX_DIM = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mme_pkg::TYPE_W-1:0]           req_req_type,
   input  logic [mme_pkg::IDX_W-1:0]            req_row,
   input  logic [mme_pkg::IDX_W-1:0]            req_col,
   input  logic signed [mme_pkg::VALUE_W-1:0]   req_value,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [mme_pkg::RESULT_W-1:0]  rsp_product_value,
   output logic                                 rsp_saturated,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [mme_pkg::DIM_W-1:0]            csr_wr_data
);

   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW    = 2 * IW;
   localparam int DEPTH = 1 << AW;

   // stores
   logic [mme_pkg::VALUE_W-1:0] mem_a [DEPTH];
   logic [mme_pkg::VALUE_W-1:0] mem_b [DEPTH];

   mme_pkg::state_type state_ff, state_in;

   logic [mme_pkg::DIM_W-1:0] dim_ff;
   logic [mme_pkg::DIM_W-1:0] len_ff, len_in;
   logic [mme_pkg::DIM_W-1:0] k_ff, k_in;
   logic [mme_pkg::IDX_W-1:0] row_ff, col_ff;
   logic                      oob_ff, oob_in;
   logic                      rd_vld_ff;
   logic signed [mme_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;

   logic                      rsp_valid_ff;
   logic [mme_pkg::IDX_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [mme_pkg::RESULT_W-1:0] rsp_value_ff;
   logic                      rsp_sat_ff;

   logic req_take;
   logic start;
   logic wr_a, wr_b;
   logic issue;
   logic run_done;
   logic drain_done;
   logic load_rsp;
   logic out_free;

   logic [IW-1:0] wr_row_idx, wr_col_idx, rd_row_idx, rd_col_idx, k_idx;

   mme_pkg::mac_ctrl_type mac_ctrl;
   mme_pkg::mac_stat_type mac_stat;
   logic [mme_pkg::RESULT_W-1:0] mac_result;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= mme_pkg::DIM_RESET;
      end else if (csr_wr_en) begin
         dim_ff <= csr_wr_data;
      end
   end

   assign req_stall = (state_ff != mme_pkg::ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   // request decode
   always_comb begin
      start = 1'b0;
      wr_a  = 1'b0;
      wr_b  = 1'b0;
      unique case (req_req_type)
         mme_pkg::REQ_LOAD_A:  wr_a  = req_take;
         mme_pkg::REQ_LOAD_B:  wr_b  = req_take;
         mme_pkg::REQ_COMPUTE: start = req_take;
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mme_pkg::ST_IDLE:  if (start)      state_in = mme_pkg::ST_RUN;
         mme_pkg::ST_RUN:   if (run_done)   state_in = mme_pkg::ST_DRAIN;
         mme_pkg::ST_DRAIN: if (drain_done) state_in = mme_pkg::ST_IDLE;
         default:                           state_in = mme_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      issue      = 1'b0;
      run_done   = 1'b0;
      drain_done = 1'b0;
      unique case (state_ff)
         mme_pkg::ST_RUN: begin
            issue    = (k_ff < len_ff);
            run_done = ~(k_ff < len_ff);
         end
         mme_pkg::ST_DRAIN: begin
            drain_done = ~rd_vld_ff & ~mac_stat.busy & out_free;
         end
         default: ;
      endcase
   end

   assign load_rsp = drain_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // compute set-up and element counter
   always_comb begin
      len_in = (32'(dim_ff) > MAX_DIM) ? mme_pkg::DIM_W'(MAX_DIM) : dim_ff;
      oob_in = (32'(req_row) >= MAX_DIM) || (32'(req_col) >= MAX_DIM);
      k_in   = k_ff;
      if (start) begin
         k_in = '0;
      end else if (issue) begin
         k_in = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff      <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         k_ff      <= k_in;
         rd_vld_ff <= issue;
      end
      if (start) begin
         len_ff <= len_in;
         oob_ff <= oob_in;
         row_ff <= req_row;
         col_ff <= req_col;
      end
   end

   // store addressing, entry at {row, col}
   assign wr_row_idx = IW'(req_row);
   assign wr_col_idx = IW'(req_col);
   assign rd_row_idx = IW'(row_ff);
   assign rd_col_idx = IW'(col_ff);
   assign k_idx      = IW'(k_ff);

   // writes happen only while idle, so a read never overlaps a write
   always_ff @(posedge clock) begin
      if (wr_a && !oob_in) begin
         mem_a[{wr_row_idx, wr_col_idx}] <= req_value;
      end
      if (wr_b && !oob_in) begin
         mem_b[{wr_row_idx, wr_col_idx}] <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_a_ff <= mem_a[{rd_row_idx, k_idx}];
         rd_b_ff <= mem_b[{k_idx, rd_col_idx}];
      end
   end

   // multiply-accumulate
   assign mac_ctrl.clear     = start;
   assign mac_ctrl.term_vld  = rd_vld_ff;
   assign mac_ctrl.term_zero = oob_ff;

   mme_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .a_data (rd_a_ff),
      .b_data (rd_b_ff),
      .stat   (mac_stat),
      .result (mac_result)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_value_ff <= mac_result;
         rsp_sat_ff   <= mac_stat.saturated;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_saturated     = rsp_sat_ff;

`include "matrix_multiply_engine_unit_assert.svh"

   `MME_ASSERT_NOW(a_k_bound, clock, reset, state_ff == mme_pkg::ST_RUN, k_ff <= len_ff, "element counter past length")
   `MME_ASSERT_NOW(a_rd_in_compute, clock, reset, rd_vld_ff, state_ff == mme_pkg::ST_RUN || state_ff == mme_pkg::ST_DRAIN, "store read outside compute")
   `MME_ASSERT_NOW(a_rsp_from_drain, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == mme_pkg::ST_DRAIN, "result without finished compute")
   `MME_ASSERT_NEXT(a_no_drop, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_value_ff), "pending result lost")

endmodule

### tb/tb.sv
// Self-checking testbench for matrix_multiply_engine_unit: element loads, C element computes, dim changes.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_DIM     = 16;
   localparam int LATENCY_PAD = MAX_DIM + 8;
   localparam int QUIET_LIMIT = 3000;
   localparam int LONG_HOLD   = 400;
   localparam int ITEM_TARGET = 1050;
   // code the block ignores
   localparam logic [mme_pkg::TYPE_W-1:0] REQ_UNUSED = 2'd3;

   typedef logic [mme_pkg::IDX_W-1:0]          idx_type;
   typedef logic signed [mme_pkg::VALUE_W-1:0] elem_type;

   typedef struct {
      idx_type                             row;
      idx_type                             col;
      logic signed [mme_pkg::RESULT_W-1:0] value;
      logic                                saturated;
   } c_element_type;

   // predicted A/B stores and the queue of C elements still owed by the block
   class c_element_model_type;
      elem_type                  a_elem [MAX_DIM][MAX_DIM];
      elem_type                  b_elem [MAX_DIM][MAX_DIM];
      logic [mme_pkg::DIM_W-1:0] dim_in_use = mme_pkg::DIM_RESET;
      c_element_type             pending_c [$];
      int unsigned               mismatches = 0;
      int unsigned               checked = 0;
      int unsigned               clamped = 0;

      function void set_dim(input logic [mme_pkg::DIM_W-1:0] d);
         dim_in_use = d;
      endfunction

      function int unsigned outstanding();
         return pending_c.size();
      endfunction

      // apply one accepted request; a compute queues the C element it produces
      function void note_request(input logic [mme_pkg::TYPE_W-1:0] kind, input idx_type row,
                                 input idx_type col, input elem_type value);
         logic signed [mme_pkg::ACC_W-1:0]     acc;
         logic signed [mme_pkg::ACC_W-1:0]     hi;
         logic signed [mme_pkg::ACC_W-1:0]     lo;
         logic signed [2*mme_pkg::VALUE_W-1:0] prod;
         int unsigned                          len;
         c_element_type                        c;
         hi = $signed({{(mme_pkg::ACC_W-mme_pkg::RESULT_W){1'b0}}, mme_pkg::Q_MAX});
         lo = $signed({{(mme_pkg::ACC_W-mme_pkg::RESULT_W){1'b1}}, mme_pkg::Q_MIN});
         case (kind)
            mme_pkg::REQ_LOAD_A: a_elem[row][col] = value;
            mme_pkg::REQ_LOAD_B: b_elem[row][col] = value;
            mme_pkg::REQ_COMPUTE: begin
               len = (dim_in_use > MAX_DIM) ? MAX_DIM : dim_in_use;
               acc = '0;
               for (int k = 0; k < len; k++) begin
                  prod = a_elem[row][k] * b_elem[k][col];
                  acc  = acc + prod;
               end
               c.saturated = 1'b0;
               if (acc > hi) begin
                  acc = hi;
                  c.saturated = 1'b1;
               end else if (acc < lo) begin
                  acc = lo;
                  c.saturated = 1'b1;
               end
               c.row   = row;
               c.col   = col;
               c.value = acc[mme_pkg::RESULT_W-1:0];
               if (c.saturated)
                  clamped++;
               pending_c.push_back(c);
            end
            default: ;
         endcase
      endfunction

      // compare one delivered C element with the oldest one owed
      function void check_c_element(input idx_type row, input idx_type col,
                                    input logic signed [mme_pkg::RESULT_W-1:0] value,
                                    input logic saturated);
         c_element_type e;
         if (pending_c.size() == 0) begin
            $error("C element row %0d col %0d arrived with none owed", row, col);
            mismatches++;
            return;
         end
         e = pending_c.pop_front();
         checked++;
         if (row !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, row);
            mismatches++;
         end
         if (col !== e.col) begin
            $error("out_col: expected %0d, got %0d", e.col, col);
            mismatches++;
         end
         if (value !== e.value) begin
            $error("product_value: expected %0d, got %0d", e.value, value);
            mismatches++;
         end
         if (saturated !== e.saturated) begin
            $error("saturated: expected %0d, got %0d", e.saturated, saturated);
            mismatches++;
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                req_valid;
   logic                                req_stall;
   logic [mme_pkg::TYPE_W-1:0]          req_req_type;
   idx_type                             req_row;
   idx_type                             req_col;
   elem_type                            req_value;
   logic                                rsp_valid;
   logic                                rsp_stall;
   idx_type                             rsp_out_row;
   idx_type                             rsp_out_col;
   logic signed [mme_pkg::RESULT_W-1:0] rsp_product_value;
   logic                                rsp_saturated;
   logic                                csr_wr_en;
   logic [mme_pkg::DIM_W-1:0]           csr_wr_data;

   c_element_model_type gemm_model = new();

   // which store entries hold data, so computes never touch unwritten ones
   bit                        a_known [MAX_DIM][MAX_DIM];
   bit                        b_known [MAX_DIM][MAX_DIM];
   logic [mme_pkg::DIM_W-1:0] cur_dim = mme_pkg::DIM_RESET;
   int unsigned               items_sent = 0;
   int unsigned               computes_sent = 0;
   int unsigned               unused_sent = 0;
   int unsigned               dim_writes = 0;
   int unsigned               calm_left = 0;
   int unsigned               quiet_cycles = 0;
   bit [31:0]                 dims_seen = '0;
   // handshake between the sender and the result side for the long hold
   bit                        hold_wanted = 1'b0;
   bit                        hold_active = 1'b0;

   matrix_multiply_engine_unit #(
      .MAX_DIM(MAX_DIM)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_req_type     (req_req_type),
      .req_row          (req_row),
      .req_col          (req_col),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_product_value(rsp_product_value),
      .rsp_saturated    (rsp_saturated),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always #6 clock = ~clock;

   // sender gap: mostly none or short, a few long, with gap-free stretches
   function automatic int unsigned draw_gap();
      int unsigned r;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // big values carry a chosen sign so that long dot products clamp
   function automatic elem_type draw_value(input bit big, input bit neg);
      if (big)
         return neg ? elem_type'(16'h8000 + 16'($urandom_range(0, 8191)))
                    : elem_type'(16'h7FFF - 16'($urandom_range(0, 8191)));
      case ($urandom_range(0, 9))
         0:       return elem_type'(16'h8000);
         1:       return elem_type'(16'h7FFF);
         2:       return elem_type'(16'h0000);
         3:       return elem_type'(16'hFFFF);
         default: return elem_type'($urandom);
      endcase
   endfunction

   function automatic int unsigned dot_len();
      return (cur_dim > MAX_DIM) ? MAX_DIM : cur_dim;
   endfunction

   // true when every entry a compute of (i, j) reads has been written
   function automatic bit covered(input idx_type i, input idx_type j);
      for (int k = 0; k < dot_len(); k++)
         if (!a_known[i][k] || !b_known[k][j])
            return 1'b0;
      return 1'b1;
   endfunction

   // offer one request after a random gap; returns at the falling edge after acceptance
   task automatic send_request(input logic [mme_pkg::TYPE_W-1:0] kind, input idx_type row,
                               input idx_type col, input elem_type value);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_req_type <= kind;
      req_row      <= row;
      req_col      <= col;
      req_value    <= value;
      do @(posedge clock); while (req_stall);
      gemm_model.note_request(kind, row, col, value);
      if (kind == mme_pkg::REQ_LOAD_A)
         a_known[row][col] = 1'b1;
      else if (kind == mme_pkg::REQ_LOAD_B)
         b_known[row][col] = 1'b1;
      if (kind == REQ_UNUSED)
         unused_sent++;
      else
         items_sent++;
      if (kind == mme_pkg::REQ_COMPUTE)
         computes_sent++;
      @(negedge clock);
   endtask

   // stop offering, let every owed C element come back, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (gemm_model.outstanding() != 0)
         @(negedge clock);
      repeat (LATENCY_PAD) @(negedge clock);
   endtask

   task automatic write_dim(input logic [mme_pkg::DIM_W-1:0] d);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= d;
      @(posedge clock);
      gemm_model.set_dim(d);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      cur_dim   = d;
      dims_seen[d] = 1'b1;
      dim_writes++;
   endtask

   // noise: unused code, or a stray load anywhere
   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_request(REQ_UNUSED, idx_type'($urandom), idx_type'($urandom),
                      elem_type'($urandom));
      else
         send_request($urandom_range(0, 1) ? mme_pkg::REQ_LOAD_B : mme_pkg::REQ_LOAD_A,
                      idx_type'($urandom), idx_type'($urandom), draw_value(1'b0, 1'b0));
   endtask

   // load row i of A and column j of B as needed, then compute C[i][j]
   task automatic run_dot_sequence();
      idx_type     i;
      idx_type     j;
      idx_type     i2;
      idx_type     j2;
      bit          big;
      bit          fresh;
      bit          neg_a;
      bit          neg_b;
      int unsigned len;
      i     = idx_type'($urandom);
      j     = idx_type'($urandom);
      big   = ($urandom_range(0, 3) == 0);
      fresh = big || ($urandom_range(0, 2) == 0);
      neg_a = 1'($urandom_range(0, 1));
      neg_b = 1'($urandom_range(0, 1));
      len   = dot_len();
      for (int k = 0; k < len; k++) begin
         if (fresh || !a_known[i][k] || $urandom_range(0, 3) == 0)
            send_request(mme_pkg::REQ_LOAD_A, i, idx_type'(k),
                         draw_value(big, neg_a ^ ($urandom_range(0, 7) == 0)));
         if (fresh || !b_known[k][j] || $urandom_range(0, 3) == 0)
            send_request(mme_pkg::REQ_LOAD_B, idx_type'(k), j,
                         draw_value(big, neg_b ^ ($urandom_range(0, 7) == 0)));
         if ($urandom_range(0, 9) == 0)
            send_noise();
      end
      // a broken sequence stops short of its compute
      if ($urandom_range(0, 9) == 0)
         return;
      send_request(mme_pkg::REQ_COMPUTE, i, j, elem_type'($urandom));
      repeat ($urandom_range(0, 2)) begin
         i2 = idx_type'($urandom);
         j2 = idx_type'($urandom);
         if (covered(i2, j2))
            send_request(mme_pkg::REQ_COMPUTE, i2, j2, elem_type'($urandom));
      end
      if ($urandom_range(0, 19) == 0)
         settle();
   endtask

   function automatic logic [mme_pkg::DIM_W-1:0] draw_dim();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 5'd31;
         2:       return mme_pkg::DIM_W'($urandom_range(MAX_DIM + 1, 30));
         3:       return mme_pkg::DIM_W'(MAX_DIM);
         4:       return 5'd1;
         default: return mme_pkg::DIM_W'($urandom_range(2, MAX_DIM));
      endcase
   endfunction

   // main stimulus
   initial begin : stimulus
      int unsigned seqs;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_req_type = mme_pkg::REQ_LOAD_A;
      req_row      = '0;
      req_col      = '0;
      req_value    = '0;
      csr_wr_en    = 1'b0;
      csr_wr_data  = mme_pkg::DIM_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: positive clamp, negative clamp, sign extremes, corner indexes
      write_dim(5'd3);
      for (int k = 0; k < 3; k++) begin
         send_request(mme_pkg::REQ_LOAD_A, '0, idx_type'(k), elem_type'(16'h8000));
         send_request(mme_pkg::REQ_LOAD_B, idx_type'(k), '0, elem_type'(16'h8000));
      end
      send_request(mme_pkg::REQ_COMPUTE, '0, '0, elem_type'(16'h7FFF));
      for (int k = 0; k < 3; k++)
         send_request(mme_pkg::REQ_LOAD_B, idx_type'(k), 4'hF, elem_type'(16'h7FFF));
      send_request(mme_pkg::REQ_COMPUTE, '0, 4'hF, elem_type'(16'h0000));
      send_request(mme_pkg::REQ_LOAD_A, 4'hF, 4'd0, elem_type'(16'h0001));
      send_request(mme_pkg::REQ_LOAD_A, 4'hF, 4'd1, elem_type'(16'hFFFF));
      send_request(mme_pkg::REQ_LOAD_A, 4'hF, 4'd2, elem_type'(16'h7FFF));
      send_request(mme_pkg::REQ_COMPUTE, 4'hF, '0, elem_type'(16'hFFFF));
      send_request(mme_pkg::REQ_COMPUTE, 4'hF, 4'hF, elem_type'(16'h8000));
      send_request(REQ_UNUSED, 4'hF, 4'hF, elem_type'(16'hFFFF));
      // empty dot product reads nothing
      write_dim('0);
      send_request(mme_pkg::REQ_COMPUTE, 4'd7, 4'd9, elem_type'($urandom));
      write_dim(5'd1);
      send_request(mme_pkg::REQ_COMPUTE, '0, '0, elem_type'($urandom));

      // long result hold while computes keep coming, so the block fills and stalls requests
      req_valid <= 1'b0;
      @(negedge clock);
      hold_wanted = 1'b1;
      wait (hold_active);
      repeat (4)
         send_request(mme_pkg::REQ_COMPUTE, '0, '0, elem_type'($urandom));
      settle();

      // random phases, each under its own dimension
      while (items_sent < ITEM_TARGET) begin
         write_dim(draw_dim());
         seqs = $urandom_range(3, 10);
         repeat (seqs)
            if (items_sent < ITEM_TARGET)
               run_dot_sequence();
      end

      settle();
      $display("Sent %0d requests (%0d computes) and %0d with the unused code",
               items_sent, computes_sent, unused_sent);
      $display("Checked %0d C elements (%0d clamped) over %0d dim writes, %0d distinct",
               gemm_model.checked, gemm_model.clamped, dim_writes, $countones(dims_seen));
      if (gemm_model.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   // result side stall: random runs, plus one long hold when the sender asks for it
   initial begin : rsp_side
      int unsigned run_len;
      int unsigned hold_len;
      bit          long_hold;
      bit          long_hold_done;
      long_hold_done = 1'b0;
      rsp_stall      = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         rsp_stall <= 1'b0;
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
         repeat (run_len) @(negedge clock);
         long_hold = !long_hold_done && hold_wanted;
         if (long_hold) begin
            long_hold_done = 1'b1;
            hold_len = LONG_HOLD;
         end else begin
            case ($urandom_range(0, 19))
               0:       hold_len = $urandom_range(30, 80);
               1, 2, 3: hold_len = $urandom_range(4, 12);
               default: hold_len = $urandom_range(1, 3);
            endcase
         end
         rsp_stall <= 1'b1;
         hold_active = long_hold;
         repeat (hold_len) @(negedge clock);
         hold_active = 1'b0;
      end
   end

   // check every accepted C element
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         gemm_model.check_c_element(rsp_out_row, rsp_out_col, rsp_product_value,
                                    rsp_saturated);
   end

   // watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
